>>> design/kme_pkg.sv
// shared types and constants for the minimum spanning tree engine
`timescale 1ns / 1ps
package kme_pkg;
  localparam int VERTEX_W         = 4;
  localparam int WEIGHT_W         = 16;
  localparam int COST_W           = 20;
  localparam int CFG_W            = 5;
  localparam int MAX_VERTICES_DEF = 16;
  localparam int MAX_EDGES_DEF    = 64;
  localparam int VC_RESET         = 16;
  localparam int MAX_CHOSEN       = 15;

  typedef struct packed {
    logic [VERTEX_W-1:0]        from_v;
    logic [VERTEX_W-1:0]        to_v;
    logic signed [WEIGHT_W-1:0] weight;
  } edge_t;
endpackage

>>> design/kme_if.sv
// valid/ready channel interfaces for edges and results
`timescale 1ns / 1ps
interface kme_edge_if;
  import kme_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [VERTEX_W-1:0]        from_vertex;
  logic [VERTEX_W-1:0]        to_vertex;
  logic signed [WEIGHT_W-1:0] edge_weight;
  logic                       last_edge;
  modport source (output valid, from_vertex, to_vertex, edge_weight, last_edge, input ready);
  modport sink (input valid, from_vertex, to_vertex, edge_weight, last_edge, output ready);
endinterface

interface kme_result_if;
  import kme_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       edge_valid;
  logic [VERTEX_W-1:0]        tree_from;
  logic [VERTEX_W-1:0]        tree_to;
  logic signed [WEIGHT_W-1:0] tree_weight;
  logic signed [COST_W-1:0]   total_cost;
  logic                       edges_dropped;
  logic                       is_last;
  modport source (output valid, edge_valid, tree_from, tree_to, tree_weight, total_cost,
                  edges_dropped, is_last, input ready);
  modport sink (input valid, edge_valid, tree_from, tree_to, tree_weight, total_cost,
                edges_dropped, is_last, output ready);
endinterface

>>> design/kme_edge_store.sv
// edge store memory, one write and one registered read port
`timescale 1ns / 1ps
module kme_edge_store #(
  parameter int MAX_EDGES = kme_pkg::MAX_EDGES_DEF
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [$clog2(MAX_EDGES)-1:0] waddr,
  input  kme_pkg::edge_t               wdata,
  input  logic [$clog2(MAX_EDGES)-1:0] raddr,
  output kme_pkg::edge_t               rdata
);
  import kme_pkg::*;
  edge_t mem [MAX_EDGES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> design/kme_parent_table.sv
// union-find parent memory with per-entry valid bits, invalid reads as own index
`timescale 1ns / 1ps
module kme_parent_table #(
  parameter int MAX_VERTICES = kme_pkg::MAX_VERTICES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            clear,
  input  logic                            we,
  input  logic [$clog2(MAX_VERTICES)-1:0] waddr,
  input  logic [$clog2(MAX_VERTICES)-1:0] wdata,
  input  logic [$clog2(MAX_VERTICES)-1:0] raddr,
  output logic [$clog2(MAX_VERTICES)-1:0] rdata
);
  localparam int VIW = $clog2(MAX_VERTICES);
  logic [VIW-1:0]          mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] valid;
  logic [VIW-1:0]          raddr_q;
  logic [VIW-1:0]          data_q;
  logic                    valid_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (clear) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    data_q  <= mem[raddr];
    valid_q <= valid[raddr];
    raddr_q <= raddr;
  end

  assign rdata = valid_q ? data_q : raddr_q;
endmodule

>>> design/kruskal_mst_engine.sv
// minimum spanning tree engine: insertion-sorted edge store and union-find selection
// load: accept the edge, shift each heavier stored edge up one slot, then write it into place
// select: read and check each stored edge visited, follow parents in each of its two root searches
// each chosen edge and the summary go into the output register, waiting while it is full
// rst is synchronous: clears control, counts, flags and parent valid bits; vertex_count goes to 16
`timescale 1ns / 1ps
module kruskal_mst_engine #(
  parameter int MAX_VERTICES = kme_pkg::MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = kme_pkg::MAX_EDGES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [kme_pkg::CFG_W-1:0]   cfg_wdata,
  kme_edge_if.sink                    in_edge,
  kme_result_if.source                out_result
);
  import kme_pkg::*;

  localparam int EIW = $clog2(MAX_EDGES);
  localparam int FW  = $clog2(MAX_EDGES + 1);
  localparam int VIW = $clog2(MAX_VERTICES);
  localparam int NW  = $clog2(MAX_VERTICES + 1);
  localparam int CW  = (NW > CFG_W) ? NW : CFG_W;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_INS_RD   = 4'd1;
  localparam logic [3:0] S_INS_CMP  = 4'd2;
  localparam logic [3:0] S_INS_PUT  = 4'd3;
  localparam logic [3:0] S_SEL_RD   = 4'd4;
  localparam logic [3:0] S_SEL_CHK  = 4'd5;
  localparam logic [3:0] S_FIND_RD  = 4'd6;
  localparam logic [3:0] S_FIND_CHK = 4'd7;
  localparam logic [3:0] S_EMIT     = 4'd8;
  localparam logic [3:0] S_SUM      = 4'd9;

  logic [3:0]               state;
  logic [CFG_W-1:0]         vertex_count;
  logic [FW-1:0]            fill;
  logic [FW-1:0]            pos;
  logic [FW-1:0]            idx;
  logic                     overflow;
  logic                     last;
  logic [3:0]               chosen;
  logic signed [COST_W-1:0] cost;
  logic                     which;
  logic [VIW-1:0]           v;
  logic [VIW-1:0]           ra;
  edge_t                    new_edge;
  edge_t                    cur;

  logic                     st_we;
  logic [EIW-1:0]           st_waddr;
  edge_t                    st_wdata;
  logic [EIW-1:0]           st_raddr;
  edge_t                    st_rdata;
  logic                     pt_clear;
  logic                     pt_we;
  logic [VIW-1:0]           pt_raddr;
  logic [VIW-1:0]           pt_rdata;

  logic [CW-1:0]            nv;
  logic                     in_xfer;
  logic                     out_free;
  logic                     in_range;
  logic                     sel_stop;
  logic signed [COST_W:0]   sum;
  logic signed [COST_W-1:0] sum_sat;

  kme_edge_store #(.MAX_EDGES(MAX_EDGES)) u_store (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  kme_parent_table #(.MAX_VERTICES(MAX_VERTICES)) u_parent (
    .clk(clk), .rst(rst), .clear(pt_clear), .we(pt_we), .waddr(ra),
    .wdata(v), .raddr(pt_raddr), .rdata(pt_rdata)
  );

  assign nv = (CW'(vertex_count) > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES)
                                                       : CW'(vertex_count);
  assign in_edge.ready = (state == S_IDLE);
  assign in_xfer  = in_edge.valid && in_edge.ready;
  assign out_free = !out_result.valid || out_result.ready;
  assign in_range = (CW'(in_edge.from_vertex) < nv) && (CW'(in_edge.to_vertex) < nv);
  assign sel_stop = (idx >= fill) || (nv < CW'(2)) || (CW'(chosen) >= nv - CW'(1)) ||
                    (chosen == 4'(MAX_CHOSEN));
  assign sum      = (COST_W + 1)'(cost) + (COST_W + 1)'(cur.weight);
  assign sum_sat  = (sum[COST_W] != sum[COST_W-1])
                    ? {sum[COST_W], {(COST_W-1){~sum[COST_W]}}} : sum[COST_W-1:0];

  always_comb begin
    st_we    = 1'b0;
    st_waddr = EIW'(pos);
    st_wdata = new_edge;
    st_raddr = EIW'(pos - FW'(1));
    pt_raddr = v;
    pt_we    = 1'b0;
    pt_clear = 1'b0;
    unique case (state)
      S_INS_CMP: begin
        st_we = 1'b1;
        if (st_rdata.weight > new_edge.weight) begin
          st_wdata = st_rdata;
        end
      end
      S_INS_PUT: st_we = 1'b1;
      S_SEL_RD: st_raddr = EIW'(idx);
      S_FIND_CHK: pt_we = (pt_rdata == v) && which && (ra != v);
      S_SUM: pt_clear = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      vertex_count     <= CFG_W'(VC_RESET);
      fill             <= '0;
      overflow         <= 1'b0;
      chosen           <= '0;
      cost             <= '0;
      out_result.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        vertex_count <= cfg_wdata;
      end
      if (out_result.valid && out_result.ready && state != S_EMIT && state != S_SUM) begin
        out_result.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            new_edge <= '{in_edge.from_vertex, in_edge.to_vertex, in_edge.edge_weight};
            last     <= in_edge.last_edge;
            pos      <= fill;
            idx      <= '0;
            if (in_range && fill < FW'(MAX_EDGES)) begin
              state <= (fill == '0) ? S_INS_PUT : S_INS_RD;
            end else begin
              if (in_range) begin
                overflow <= 1'b1;
              end
              state <= in_edge.last_edge ? S_SEL_RD : S_IDLE;
            end
          end
        end
        S_INS_RD: state <= S_INS_CMP;
        S_INS_CMP: begin
          if (st_rdata.weight > new_edge.weight) begin
            pos   <= pos - FW'(1);
            state <= (pos == FW'(1)) ? S_INS_PUT : S_INS_RD;
          end else begin
            fill  <= fill + FW'(1);
            state <= last ? S_SEL_RD : S_IDLE;
          end
        end
        S_INS_PUT: begin
          fill  <= fill + FW'(1);
          state <= last ? S_SEL_RD : S_IDLE;
        end
        S_SEL_RD: state <= sel_stop ? S_SUM : S_SEL_CHK;
        S_SEL_CHK: begin
          cur <= st_rdata;
          if (CW'(st_rdata.from_v) >= nv || CW'(st_rdata.to_v) >= nv) begin
            idx   <= idx + FW'(1);
            state <= S_SEL_RD;
          end else begin
            v     <= VIW'(st_rdata.from_v);
            which <= 1'b0;
            state <= S_FIND_RD;
          end
        end
        S_FIND_RD: state <= S_FIND_CHK;
        S_FIND_CHK: begin
          if (pt_rdata != v) begin
            v     <= pt_rdata;
            state <= S_FIND_RD;
          end else if (!which) begin
            ra    <= v;
            v     <= VIW'(cur.to_v);
            which <= 1'b1;
            state <= S_FIND_RD;
          end else if (ra == v) begin
            idx   <= idx + FW'(1);
            state <= S_SEL_RD;
          end else begin
            cost   <= sum_sat;
            chosen <= chosen + 4'd1;
            state  <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_result.valid         <= 1'b1;
            out_result.edge_valid    <= 1'b1;
            out_result.tree_from     <= cur.from_v;
            out_result.tree_to       <= cur.to_v;
            out_result.tree_weight   <= cur.weight;
            out_result.total_cost    <= cost;
            out_result.edges_dropped <= overflow;
            out_result.is_last       <= 1'b0;
            idx                      <= idx + FW'(1);
            state                    <= S_SEL_RD;
          end
        end
        S_SUM: begin
          if (out_free) begin
            out_result.valid         <= 1'b1;
            out_result.edge_valid    <= 1'b0;
            out_result.tree_from     <= '0;
            out_result.tree_to       <= '0;
            out_result.tree_weight   <= '0;
            out_result.total_cost    <= cost;
            out_result.edges_dropped <= overflow;
            out_result.is_last       <= 1'b1;
            fill                     <= '0;
            overflow                 <= 1'b0;
            chosen                   <= '0;
            cost                     <= '0;
            state                    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(MAX_EDGES)) else $error("edge fill beyond store size");
  a_chosen_bound: assert property (@(posedge clk) disable iff (rst)
    chosen <= 4'(MAX_CHOSEN)) else $error("chosen count beyond limit");
  a_summary_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_SUM && out_free) |=> (fill == '0 && chosen == '0 && !overflow))
    else $error("graph state not cleared after summary");
  a_last_no_edge: assert property (@(posedge clk) disable iff (rst)
    (out_result.valid && out_result.is_last) |-> !out_result.edge_valid)
    else $error("summary marked as tree edge");
`endif
endmodule

>>> bench/kruskal_mst_engine_test.sv
// testbench for the kruskal minimum spanning tree engine with a scoreboard class
`timescale 1ns / 1ps
module kruskal_mst_engine_test;
  import kme_pkg::*;

  typedef struct packed {
    logic        edge_valid;
    logic [3:0]  tree_from;
    logic [3:0]  tree_to;
    logic [15:0] tree_weight;
    logic [19:0] total_cost;
    logic        edges_dropped;
    logic        is_last;
  } tree_item_t;

  class mst_scoreboard;
    edge_t      stored[$];
    logic [3:0] parent[16];
    bit         dropped;
    int         vcount;
    tree_item_t pending[$];
    int         mismatches;

    function new();
      stored.delete();
      dropped = 0;
      vcount = VC_RESET;
      mismatches = 0;
    endfunction

    function void set_vertices(int v);
      vcount = v;
    endfunction

    function int find_root(int v);
      int steps;
      for (steps = 0; steps < 16; steps++) begin
        if (parent[v] == v) break;
        v = parent[v];
      end
      return v;
    endfunction

    function void note_edge(logic [3:0] f, logic [3:0] t, logic signed [15:0] w, logic lst);
      edge_t e;
      edge_t srt[$];
      int nv, chosen, ra, rb, j, k;
      logic signed [19:0] cost;
      tree_item_t r;
      nv = (vcount > 16) ? 16 : vcount;
      if (f < nv && t < nv) begin
        if (stored.size() < MAX_EDGES_DEF) begin
          e.from_v = f;
          e.to_v = t;
          e.weight = w;
          stored.push_back(e);
        end else dropped = 1;
      end
      if (!lst) return;
      srt = stored;
      for (int i = 1; i < srt.size(); i++) begin
        e = srt[i];
        j = i;
        while (j > 0 && srt[j-1].weight > e.weight) begin
          srt[j] = srt[j-1];
          j--;
        end
        srt[j] = e;
      end
      for (int i = 0; i < 16; i++) parent[i] = i;
      chosen = 0;
      cost = 0;
      k = 0;
      foreach (srt[i]) begin
        if (nv < 2 || chosen >= nv - 1 || k >= MAX_CHOSEN) break;
        if (srt[i].from_v >= nv || srt[i].to_v >= nv) continue;
        ra = find_root(srt[i].from_v);
        rb = find_root(srt[i].to_v);
        if (ra == rb) continue;
        cost = cost + 20'(srt[i].weight);
        parent[ra] = rb;
        chosen++;
        r.edge_valid = 1;
        r.tree_from = srt[i].from_v;
        r.tree_to = srt[i].to_v;
        r.tree_weight = srt[i].weight;
        r.total_cost = cost;
        r.edges_dropped = dropped;
        r.is_last = 0;
        pending.push_back(r);
        k++;
      end
      r.edge_valid = 0;
      r.tree_from = 0;
      r.tree_to = 0;
      r.tree_weight = 0;
      r.total_cost = cost;
      r.edges_dropped = dropped;
      r.is_last = 1;
      pending.push_back(r);
      stored.delete();
      dropped = 0;
    endfunction

    function void check_result(tree_item_t got);
      tree_item_t exp;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %p", got);
        return;
      end
      exp = pending.pop_front();
      if (got !== exp) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [CFG_W-1:0] cfg_wdata = 0;
  int send_idle, recv_idle;
  int quiet_cycles;
  mst_scoreboard board;

  kme_edge_if in_edge();
  kme_result_if out_result();

  kruskal_mst_engine i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_edge(in_edge.sink), .out_result(out_result.source)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_result.ready <= !rst && ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    tree_item_t got;
    if (!rst && out_result.valid && out_result.ready) begin
      got.edge_valid = out_result.edge_valid;
      got.tree_from = out_result.tree_from;
      got.tree_to = out_result.tree_to;
      got.tree_weight = out_result.tree_weight;
      got.total_cost = out_result.total_cost;
      got.edges_dropped = out_result.edges_dropped;
      got.is_last = out_result.is_last;
      board.check_result(got);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_edge.valid && in_edge.ready) || (out_result.valid && out_result.ready))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 200000) begin
      $display("kruskal_mst_engine_test: errors");
      $finish;
    end
  end

  task automatic send_edge(int f, int t, int w, bit lst);
    @(posedge clk);
    while ($urandom_range(99) < send_idle) @(posedge clk);
    in_edge.valid <= 1;
    in_edge.from_vertex <= 4'(f);
    in_edge.to_vertex <= 4'(t);
    in_edge.edge_weight <= 16'(w);
    in_edge.last_edge <= lst;
    @(posedge clk);
    while (!in_edge.ready) @(posedge clk);
    board.note_edge(4'(f), 4'(t), 16'(w), lst);
    in_edge.valid <= 0;
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_count(int v);
    drain();
    cfg_we <= 1;
    cfg_wdata <= CFG_W'(v);
    @(posedge clk);
    cfg_we <= 0;
    board.set_vertices(v);
  endtask

  task automatic random_graph(int n, int span);
    for (int i = 0; i < n; i++)
      send_edge($urandom_range(span - 1), $urandom_range(span - 1),
                ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(40) - 20,
                i == n - 1);
  endtask

  initial begin
    board = new();
    send_idle = 0;
    recv_idle = 0;
    in_edge.valid = 0;
    in_edge.from_vertex = 0;
    in_edge.to_vertex = 0;
    in_edge.edge_weight = 0;
    in_edge.last_edge = 0;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: extremes, self loop, ties, out of range, tiny counts
    send_edge(0, 15, 32767, 0);
    send_edge(15, 0, -32768, 0);
    send_edge(3, 3, -100, 0);
    send_edge(1, 2, 5, 0);
    send_edge(2, 1, 5, 0);
    send_edge(4, 5, 5, 1);
    write_count(1);
    send_edge(0, 0, 7, 1);
    write_count(0);
    send_edge(0, 1, 7, 1);
    write_count(31);
    send_edge(10, 11, 3, 1);
    write_count(3);
    send_edge(0, 5, 1, 0);
    send_edge(0, 1, 2, 0);
    send_edge(1, 2, 3, 1);
    write_count(2);
    send_edge(9, 9, 1, 1);
    // store overflow, with dropped last edge
    write_count(16);
    for (int i = 0; i < 66; i++) send_edge($urandom_range(15), $urandom_range(15),
                                           $urandom_range(65535), i == 65);
    drain();
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 31 : (ph == 1) ? 79 : 0;
      recv_idle = (ph == 0) ? 79 : (ph == 1) ? 31 : 0;
      write_count((ph == 2) ? 16 : $urandom_range(2, 17));
      for (int g = 0; g < 11; g++) begin
        random_graph($urandom_range(1, 12), 16);
      end
    end
    drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (board.mismatches == 0) $display("kruskal_mst_engine_test: clean");
    else $display("kruskal_mst_engine_test: errors");
    $finish;
  end
endmodule
